[rtl/core/ibem_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibem_pkg: shared constants and types
// Widths, calibration length and lane control bundle for the IMU bias/EMA core.
// ----------------------------------------------------------------------------
package ibem_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int FRAC_W      = 16;
  localparam int STATE_W     = SAMPLE_W + FRAC_W;
  localparam int ALPHA_W     = 16;
  localparam int DIFF_W      = STATE_W + 1;
  localparam int PROD_W      = DIFF_W + ALPHA_W + 1;
  localparam int STEP_W      = PROD_W - FRAC_W;
  localparam int NUM_AXES    = 3;

  // Calibration length is a power of two so the means are plain shifts
  localparam int CAL_LOG2    = 6;
  localparam int CAL_SAMPLES = 1 << CAL_LOG2;
  localparam int CNT_W       = CAL_LOG2 + 1;
  localparam int SUM_W       = SAMPLE_W + CAL_LOG2;

  localparam int SQ_W        = 2 * SAMPLE_W;
  localparam int MAG_W       = 16;
  localparam int MAG_MAX     = 56756;
  localparam int ROOT_STEPS  = SQ_W / 2;
  localparam int STEP_CNT_W  = $clog2(ROOT_STEPS);
  localparam int REM_W       = MAG_W + 1;

  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd6554;

  // Strobes from the sequencer to every filter lane
  typedef struct packed {
    logic cal_add;   // add the held sample into the calibration sum
    logic cal_last;  // this sample completes calibration
    logic diff_en;   // form input minus state
    logic mul_en;    // multiply by alpha
    logic upd_en;    // add the scaled step into the state
  } lane_ctrl_t;

endpackage

[rtl/core/ibem_lane.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibem_lane: one axis of calibration and EMA filtering
// Sums calibration samples, seeds the filter, removes gyro bias and runs
// state += alpha * (in - state) over sequenced difference, multiply and update steps.
// ----------------------------------------------------------------------------
module ibem_lane (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  ibem_pkg::lane_ctrl_t                  ctrl,
  input  logic                                  bias_en,
  input  logic        [ibem_pkg::ALPHA_W-1:0]   alpha,
  input  logic signed [ibem_pkg::SAMPLE_W-1:0]  sample,
  output logic signed [ibem_pkg::SAMPLE_W-1:0]  filt_q
);

  logic signed [ibem_pkg::SUM_W-1:0]    sum_r;
  logic signed [ibem_pkg::SUM_W-1:0]    sum_nxt;
  logic signed [ibem_pkg::SAMPLE_W-1:0] offset_r;
  logic signed [ibem_pkg::STATE_W-1:0]  state_r;
  logic signed [ibem_pkg::DIFF_W-1:0]   diff_r;
  logic signed [ibem_pkg::DIFF_W-1:0]   diff_nxt;
  logic signed [ibem_pkg::PROD_W-1:0]   prod_r;
  logic signed [ibem_pkg::PROD_W-1:0]   prod_nxt;
  logic signed [ibem_pkg::SAMPLE_W:0]   corr_wide;
  logic signed [ibem_pkg::SAMPLE_W-1:0] corr;
  logic signed [ibem_pkg::STEP_W-1:0]   step;
  logic signed [ibem_pkg::STEP_W-1:0]   state_sum;

  // Running calibration sum including the current sample
  assign sum_nxt = sum_r + {{ibem_pkg::CAL_LOG2{sample[ibem_pkg::SAMPLE_W-1]}}, sample};

  // Remove bias and saturate to the sample range
  always_comb begin
    corr_wide = {sample[ibem_pkg::SAMPLE_W-1], sample}
              - {offset_r[ibem_pkg::SAMPLE_W-1], offset_r};
    if (!bias_en) begin
      corr = sample;
    end else if (corr_wide[ibem_pkg::SAMPLE_W] != corr_wide[ibem_pkg::SAMPLE_W-1]) begin
      corr = corr_wide[ibem_pkg::SAMPLE_W] ? {1'b1, {(ibem_pkg::SAMPLE_W-1){1'b0}}}
                                           : {1'b0, {(ibem_pkg::SAMPLE_W-1){1'b1}}};
    end else begin
      corr = corr_wide[ibem_pkg::SAMPLE_W-1:0];
    end
  end

  // Difference, product and floor-shifted step
  assign diff_nxt  = {corr[ibem_pkg::SAMPLE_W-1], corr, {ibem_pkg::FRAC_W{1'b0}}}
                   - {state_r[ibem_pkg::STATE_W-1], state_r};
  assign prod_nxt  = $signed({1'b0, alpha}) * diff_r;
  assign step      = prod_r[ibem_pkg::PROD_W-1:ibem_pkg::FRAC_W];
  assign state_sum = {{(ibem_pkg::STEP_W-ibem_pkg::STATE_W){state_r[ibem_pkg::STATE_W-1]}},
                      state_r} + step;

  // Architectural state: sums, bias and filter value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r    <= '0;
      offset_r <= '0;
      state_r  <= '0;
    end else begin
      if (ctrl.cal_add) begin
        sum_r <= sum_nxt;
      end
      if (ctrl.cal_last) begin
        offset_r <= sum_nxt[ibem_pkg::SUM_W-1:ibem_pkg::CAL_LOG2];
        state_r  <= bias_en ? '0
                  : {sum_nxt, {(ibem_pkg::FRAC_W-ibem_pkg::CAL_LOG2){1'b0}}};
      end else if (ctrl.upd_en) begin
        state_r <= state_sum[ibem_pkg::STATE_W-1:0];
      end
    end
  end

  // Datapath pipeline registers
  always_ff @(posedge clk) begin
    if (ctrl.diff_en) begin
      diff_r <= diff_nxt;
    end
    if (ctrl.mul_en) begin
      prod_r <= prod_nxt;
    end
  end

  // Truncate to the input scale
  assign filt_q = state_r[ibem_pkg::STATE_W-1:ibem_pkg::FRAC_W];

endmodule

[rtl/core/ibem_mag.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibem_mag: vector magnitude of three filtered axes
// Sums the squares one axis per cycle, then takes the integer square root
// one result bit per cycle.
// ----------------------------------------------------------------------------
module ibem_mag (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  input  logic signed [ibem_pkg::SAMPLE_W-1:0]  vec [ibem_pkg::NUM_AXES],
  output logic                                  busy,
  output logic        [ibem_pkg::MAG_W-1:0]     mag
);

  typedef enum logic [1:0] {
    M_IDLE,
    M_SQ,
    M_ROOT
  } mag_state_t;

  mag_state_t                           st_r;
  logic [ibem_pkg::STEP_CNT_W-1:0]      cnt_r;
  logic signed [ibem_pkg::SAMPLE_W-1:0] vals_r [ibem_pkg::NUM_AXES];
  logic [ibem_pkg::SQ_W-1:0]            sq_r;
  logic [ibem_pkg::SQ_W-1:0]            acc_r;
  logic [ibem_pkg::SQ_W-1:0]            rad_r;
  logic [ibem_pkg::REM_W-1:0]           rem_r;
  logic [ibem_pkg::MAG_W-1:0]           root_r;
  logic [ibem_pkg::MAG_W-1:0]           mag_r;
  logic signed [ibem_pkg::SQ_W-1:0]     sq_nxt;
  logic [ibem_pkg::REM_W+1:0]           rem_sh;
  logic [ibem_pkg::REM_W+1:0]           trial;
  logic [ibem_pkg::REM_W-1:0]           rem_nxt;
  logic [ibem_pkg::MAG_W-1:0]           root_nxt;

  assign sq_nxt = vals_r[0] * vals_r[0];

  // One restoring square root step
  always_comb begin
    rem_sh = {rem_r, rad_r[ibem_pkg::SQ_W-1:ibem_pkg::SQ_W-2]};
    trial  = {1'b0, root_r, 2'b01};
    if (rem_sh >= trial) begin
      rem_nxt  = rem_sh[ibem_pkg::REM_W-1:0] - trial[ibem_pkg::REM_W-1:0];
      root_nxt = {root_r[ibem_pkg::MAG_W-2:0], 1'b1};
    end else begin
      rem_nxt  = rem_sh[ibem_pkg::REM_W-1:0];
      root_nxt = {root_r[ibem_pkg::MAG_W-2:0], 1'b0};
    end
  end

  // Sequence squares then root steps
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= M_IDLE;
      cnt_r <= '0;
    end else begin
      unique case (st_r)
        M_IDLE: begin
          if (start) begin
            st_r  <= M_SQ;
            cnt_r <= '0;
          end
        end
        M_SQ: begin
          if (cnt_r == ibem_pkg::STEP_CNT_W'(ibem_pkg::NUM_AXES)) begin
            st_r  <= M_ROOT;
            cnt_r <= '0;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        M_ROOT: begin
          if (cnt_r == ibem_pkg::STEP_CNT_W'(ibem_pkg::ROOT_STEPS - 1)) begin
            st_r <= M_IDLE;
          end
          cnt_r <= cnt_r + 1'b1;
        end
        default: st_r <= M_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (st_r)
      M_IDLE: begin
        if (start) begin
          vals_r <= vec;
          acc_r  <= '0;
        end
      end
      M_SQ: begin
        sq_r      <= sq_nxt;
        vals_r[0] <= vals_r[1];
        vals_r[1] <= vals_r[2];
        if (cnt_r != '0) begin
          acc_r <= acc_r + sq_r;
        end
        if (cnt_r == ibem_pkg::STEP_CNT_W'(ibem_pkg::NUM_AXES)) begin
          rad_r  <= acc_r + sq_r;
          rem_r  <= '0;
          root_r <= '0;
        end
      end
      M_ROOT: begin
        rad_r  <= {rad_r[ibem_pkg::SQ_W-3:0], 2'b00};
        rem_r  <= rem_nxt;
        root_r <= root_nxt;
        if (cnt_r == ibem_pkg::STEP_CNT_W'(ibem_pkg::ROOT_STEPS - 1)) begin
          mag_r <= root_nxt;
        end
      end
      default: begin
        acc_r <= acc_r;
      end
    endcase
  end

  assign busy = (st_r != M_IDLE);
  assign mag  = mag_r;

endmodule

[rtl/core/imu_bias_ema_magnitude_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_bias_ema_magnitude_core: IMU calibration, EMA smoothing, magnitudes
// Six filter lanes run side by side; two magnitude units merge their results.
//
//   channel  handshake               payload
//   in       in_valid / in_ready     in_accel_x/y/z, in_gyro_x/y/z
//   out      out_valid / out_ready   out_filt_*, out_accel_norm, out_gyro_norm
//   cfg      cfg_valid / cfg_ready   cfg_filter_alpha (always ready)
//
// A calibration sample gives no result. A filtered sample passes ST_DIFF,
// ST_MUL, ST_UPD and ST_MAG, waits in ST_WAIT mostly on the 16-step square
// root in the magnitude units and raises out_valid from ST_PUSH once the output
// register is free or being read; the next sample can then transfer in ST_IDLE.
// One sample is in work at a time; the next transfer is taken while a
// result still waits in the output register.
// Reset is synchronous: alpha returns to 6554 and calibration restarts.
// ----------------------------------------------------------------------------
module imu_bias_ema_magnitude_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [ibem_pkg::SAMPLE_W-1:0]  in_accel_x,
  input  logic signed [ibem_pkg::SAMPLE_W-1:0]  in_accel_y,
  input  logic signed [ibem_pkg::SAMPLE_W-1:0]  in_accel_z,
  input  logic signed [ibem_pkg::SAMPLE_W-1:0]  in_gyro_x,
  input  logic signed [ibem_pkg::SAMPLE_W-1:0]  in_gyro_y,
  input  logic signed [ibem_pkg::SAMPLE_W-1:0]  in_gyro_z,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [ibem_pkg::SAMPLE_W-1:0]  out_filt_accel_x,
  output logic signed [ibem_pkg::SAMPLE_W-1:0]  out_filt_accel_y,
  output logic signed [ibem_pkg::SAMPLE_W-1:0]  out_filt_accel_z,
  output logic signed [ibem_pkg::SAMPLE_W-1:0]  out_filt_gyro_x,
  output logic signed [ibem_pkg::SAMPLE_W-1:0]  out_filt_gyro_y,
  output logic signed [ibem_pkg::SAMPLE_W-1:0]  out_filt_gyro_z,
  output logic        [ibem_pkg::MAG_W-1:0]     out_accel_norm,
  output logic        [ibem_pkg::MAG_W-1:0]     out_gyro_norm,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic        [ibem_pkg::ALPHA_W-1:0]   cfg_filter_alpha
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CAL,
    ST_DIFF,
    ST_MUL,
    ST_UPD,
    ST_MAG,
    ST_WAIT,
    ST_PUSH
  } core_state_t;

  core_state_t                          st_r;
  core_state_t                          st_nxt;
  logic [ibem_pkg::CNT_W-1:0]           cal_cnt_r;
  logic [ibem_pkg::ALPHA_W-1:0]         alpha_r;
  logic signed [ibem_pkg::SAMPLE_W-1:0] acc_samp_r  [ibem_pkg::NUM_AXES];
  logic signed [ibem_pkg::SAMPLE_W-1:0] gyr_samp_r  [ibem_pkg::NUM_AXES];
  logic signed [ibem_pkg::SAMPLE_W-1:0] acc_filt    [ibem_pkg::NUM_AXES];
  logic signed [ibem_pkg::SAMPLE_W-1:0] gyr_filt    [ibem_pkg::NUM_AXES];
  logic signed [ibem_pkg::SAMPLE_W-1:0] acc_out_r   [ibem_pkg::NUM_AXES];
  logic signed [ibem_pkg::SAMPLE_W-1:0] gyr_out_r   [ibem_pkg::NUM_AXES];
  logic [ibem_pkg::MAG_W-1:0]           acc_mag;
  logic [ibem_pkg::MAG_W-1:0]           gyr_mag;
  logic [ibem_pkg::MAG_W-1:0]           acc_mag_r;
  logic [ibem_pkg::MAG_W-1:0]           gyr_mag_r;
  logic                                 acc_busy;
  logic                                 gyr_busy;
  logic                                 out_valid_r;
  logic                                 in_xfer;
  logic                                 out_xfer;
  logic                                 cal_done;
  logic                                 load_out;
  ibem_pkg::lane_ctrl_t                 lane_ctrl;

  assign in_ready  = (st_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_xfer   = in_valid && in_ready;
  assign out_xfer  = out_valid_r && out_ready;
  assign cal_done  = (cal_cnt_r == ibem_pkg::CNT_W'(ibem_pkg::CAL_SAMPLES));
  assign load_out  = (st_r == ST_PUSH) && (!out_valid_r || out_ready);

  // Lane strobes follow the sequencer state
  always_comb begin
    lane_ctrl.cal_add  = (st_r == ST_CAL);
    lane_ctrl.cal_last = (st_r == ST_CAL)
                       && (cal_cnt_r == ibem_pkg::CNT_W'(ibem_pkg::CAL_SAMPLES - 1));
    lane_ctrl.diff_en  = (st_r == ST_DIFF);
    lane_ctrl.mul_en   = (st_r == ST_MUL);
    lane_ctrl.upd_en   = (st_r == ST_UPD);
  end

  // Next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: if (in_xfer) st_nxt = cal_done ? ST_DIFF : ST_CAL;
      ST_CAL:  st_nxt = ST_IDLE;
      ST_DIFF: st_nxt = ST_MUL;
      ST_MUL:  st_nxt = ST_UPD;
      ST_UPD:  st_nxt = ST_MAG;
      ST_MAG:  st_nxt = ST_WAIT;
      ST_WAIT: if (!acc_busy && !gyr_busy) st_nxt = ST_PUSH;
      ST_PUSH: if (load_out) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  // Sequencer state, calibration count, config and output valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      cal_cnt_r   <= '0;
      alpha_r     <= ibem_pkg::ALPHA_RESET;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (cfg_valid && cfg_ready) begin
        alpha_r <= cfg_filter_alpha;
      end
      if (st_r == ST_CAL) begin
        cal_cnt_r <= cal_cnt_r + 1'b1;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_xfer) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      acc_samp_r[0] <= in_accel_x;
      acc_samp_r[1] <= in_accel_y;
      acc_samp_r[2] <= in_accel_z;
      gyr_samp_r[0] <= in_gyro_x;
      gyr_samp_r[1] <= in_gyro_y;
      gyr_samp_r[2] <= in_gyro_z;
    end
    if (load_out) begin
      acc_out_r <= acc_filt;
      gyr_out_r <= gyr_filt;
      acc_mag_r <= acc_mag;
      gyr_mag_r <= gyr_mag;
    end
  end

  // Filter lanes, one accel and one gyro lane per axis
  for (genvar i = 0; i < ibem_pkg::NUM_AXES; i++) begin : g_axis
    ibem_lane u_acc_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctrl    (lane_ctrl),
      .bias_en (1'b0),
      .alpha   (alpha_r),
      .sample  (acc_samp_r[i]),
      .filt_q  (acc_filt[i])
    );
    ibem_lane u_gyr_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctrl    (lane_ctrl),
      .bias_en (1'b1),
      .alpha   (alpha_r),
      .sample  (gyr_samp_r[i]),
      .filt_q  (gyr_filt[i])
    );
  end

  // Merge: magnitudes of both vectors
  ibem_mag u_acc_mag (
    .clk   (clk),
    .rst_n (rst_n),
    .start (st_r == ST_MAG),
    .vec   (acc_filt),
    .busy  (acc_busy),
    .mag   (acc_mag)
  );

  ibem_mag u_gyr_mag (
    .clk   (clk),
    .rst_n (rst_n),
    .start (st_r == ST_MAG),
    .vec   (gyr_filt),
    .busy  (gyr_busy),
    .mag   (gyr_mag)
  );

  assign out_valid        = out_valid_r;
  assign out_filt_accel_x = acc_out_r[0];
  assign out_filt_accel_y = acc_out_r[1];
  assign out_filt_accel_z = acc_out_r[2];
  assign out_filt_gyro_x  = gyr_out_r[0];
  assign out_filt_gyro_y  = gyr_out_r[1];
  assign out_filt_gyro_z  = gyr_out_r[2];
  assign out_accel_norm   = acc_mag_r;
  assign out_gyro_norm    = gyr_mag_r;

endmodule

[rtl/core/ibem_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibem_checker: port-level checks for the IMU bias/EMA core
// Watches the top-level ports only and is bound to the top level.
// ----------------------------------------------------------------------------
module ibem_checker (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  in_valid,
  input logic                                  in_ready,
  input logic                                  out_valid,
  input logic                                  out_ready,
  input logic signed [ibem_pkg::SAMPLE_W-1:0]  out_filt_accel_x,
  input logic signed [ibem_pkg::SAMPLE_W-1:0]  out_filt_gyro_x,
  input logic        [ibem_pkg::MAG_W-1:0]     out_accel_norm,
  input logic        [ibem_pkg::MAG_W-1:0]     out_gyro_norm
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_filt_accel_x)
      && $stable(out_filt_gyro_x) && $stable(out_accel_norm))
    else $error("stalled result changed");

  // One sample in work: ready drops after every input transfer
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a sample is in work");

  // No result right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Magnitudes of 16-bit vectors stay within their bound
  a_mag_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_accel_norm <= ibem_pkg::MAG_W'(ibem_pkg::MAG_MAX))
      && (out_gyro_norm <= ibem_pkg::MAG_W'(ibem_pkg::MAG_MAX)))
    else $error("magnitude out of range");

endmodule

bind imu_bias_ema_magnitude_core ibem_checker u_ibem_checker (.*);
